@@ rtl/core/itoa_pkg.sv @@
// ---------------------------------------------------------------------------
// itoa_pkg
// shared sizes, codes, command/status bundles and the digit-to-ascii map
// ---------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int MaxDigits      = 64;
  localparam int CharsPerResult = 4;

  localparam int ValueW     = 64;
  localparam int StoreDepth = 64;
  localparam int CharFields = 4;
  localparam int PadLimit   = (MaxDigits > StoreDepth) ? StoreDepth : MaxDigits;
  localparam int GroupWidth = (CharsPerResult < 1) ? 1 :
                              ((CharsPerResult > CharFields) ? CharFields : CharsPerResult);

  localparam int AddrW    = $clog2(StoreDepth);
  localparam int CntW     = $clog2(StoreDepth + 2);
  localparam int SlotW    = $clog2(CharFields + 1);
  localparam int IdxW     = $clog2(CharFields);
  localparam int DigitW   = 4;
  localparam int BcdDigits = 20;
  localparam int WorkW    = BcdDigits * DigitW;
  localparam int ModeW    = 3;
  localparam int MinDigW  = 7;
  localparam int CountW   = 3;
  localparam int CharW    = 8;

  localparam logic [ModeW-1:0] ModeDec    = 3'd0;
  localparam logic [ModeW-1:0] ModeBin    = 3'd1;
  localparam logic [ModeW-1:0] ModeOct    = 3'd2;
  localparam logic [ModeW-1:0] ModeHexLow = 3'd3;
  localparam logic [ModeW-1:0] ModeHexUp  = 3'd4;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;

  typedef struct packed {
    logic load;
    logic conv;
    logic dig;
    logic pad;
    logic grp_start;
    logic fill;
    logic next_grp;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic dig_done;
    logic pad_done;
    logic fill_done;
    logic last;
  } status_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d,
                                                     input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CharUpA : CharLowA;
    if (d > 4'd9) begin
      return base + {4'b0, d} - 8'd10;
    end
    return CharZero + {4'b0, d};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/integer_to_ascii_radix_core.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_core
// 64-bit integer to ascii text in decimal, binary, octal or hex, with zero
// padding and a leading minus, handed out in groups of up to four characters
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | sink      | in_valid_i / in_stall_o | value, is_signed, mode, min_digits
//  out     | source    | out_valid_o / out_stall_i | four chars, char_count, is_last
//
// one word at a time: in_stall_o is high from acceptance until the last group is
// taken. decimal words pass through the bcd unit first, the other radices skip it;
// then the digits and the pad digits go to the digit store, and each group is
// filled with characters from the store (registered read), then handed off.
// async active-low reset returns the sequencer to idle; out_stall_i holds a group.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [itoa_pkg::ValueW-1:0]  value_i,
  input  wire logic                         is_signed_i,
  input  wire logic [itoa_pkg::ModeW-1:0]   mode_i,
  input  wire logic [itoa_pkg::MinDigW-1:0] min_digits_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [itoa_pkg::CharW-1:0]   char_first_o,
  output logic      [itoa_pkg::CharW-1:0]   char_second_o,
  output logic      [itoa_pkg::CharW-1:0]   char_third_o,
  output logic      [itoa_pkg::CharW-1:0]   char_fourth_o,
  output logic      [itoa_pkg::CountW-1:0]  char_count_o,
  output logic                              is_last_o
);

  itoa_pkg::cmd_t    cmd;
  itoa_pkg::status_t status;

  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  itoa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (value_i),
    .is_signed_i   (is_signed_i),
    .mode_i        (mode_i),
    .min_digits_i  (min_digits_i),
    .char_first_o  (char_first_o),
    .char_second_o (char_second_o),
    .char_third_o  (char_third_o),
    .char_fourth_o (char_fourth_o),
    .char_count_o  (char_count_o),
    .is_last_o     (is_last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/itoa_ram.sv @@
// ---------------------------------------------------------------------------
// itoa_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/itoa_dp.sv @@
// ---------------------------------------------------------------------------
// itoa_dp
// datapath: magnitude, bcd conversion, digit store and character groups
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire itoa_pkg::cmd_t                  cmd_i,
  output itoa_pkg::status_t                    status_o,
  input  wire logic [itoa_pkg::ValueW-1:0]     value_i,
  input  wire logic                            is_signed_i,
  input  wire logic [itoa_pkg::ModeW-1:0]      mode_i,
  input  wire logic [itoa_pkg::MinDigW-1:0]    min_digits_i,
  output logic      [itoa_pkg::CharW-1:0]      char_first_o,
  output logic      [itoa_pkg::CharW-1:0]      char_second_o,
  output logic      [itoa_pkg::CharW-1:0]      char_third_o,
  output logic      [itoa_pkg::CharW-1:0]      char_fourth_o,
  output logic      [itoa_pkg::CountW-1:0]     char_count_o,
  output logic                                 is_last_o
);

  // control registers
  logic [itoa_pkg::CntW-1:0]   n_q, n_d;
  logic [itoa_pkg::CntW-1:0]   conv_cnt_q, conv_cnt_d;
  logic [itoa_pkg::CntW-1:0]   txt_pos_q, txt_pos_d;
  logic [itoa_pkg::SlotW-1:0]  slot_q, slot_d;
  logic                        pend_valid_q, pend_valid_d;

  // payload registers
  logic [itoa_pkg::ValueW-1:0] bin_q;
  logic [itoa_pkg::WorkW-1:0]  work_q;
  logic [itoa_pkg::ModeW-1:0]  mode_q;
  logic                        dec_q;
  logic                        upper_q;
  logic                        neg_q;
  logic [itoa_pkg::MinDigW-1:0] pad_q;
  logic [itoa_pkg::IdxW-1:0]   pend_slot_q;
  logic                        pend_sign_q;
  logic [itoa_pkg::CharW-1:0]  chars_q [itoa_pkg::CharFields];

  logic                        neg_in;
  logic [itoa_pkg::ValueW-1:0] mag;
  logic [itoa_pkg::WorkW-1:0]  bcd_adj;
  logic [itoa_pkg::DigitW-1:0] digit;
  logic [itoa_pkg::WorkW-1:0]  work_shr;
  logic                        conv_step;
  logic [itoa_pkg::CntW-1:0]   len;
  logic [itoa_pkg::CntW-1:0]   rem;
  logic [itoa_pkg::SlotW-1:0]  grp_cnt;
  logic [itoa_pkg::CntW-1:0]   char_pos;
  logic                        sign_pos;
  logic                        issue;
  logic                        ram_we;
  logic [itoa_pkg::DigitW-1:0] ram_wdata;
  logic                        ram_re;
  logic [itoa_pkg::CntW-1:0]   rd_idx;
  logic [itoa_pkg::DigitW-1:0] ram_rdata;

  assign neg_in = is_signed_i & value_i[itoa_pkg::ValueW-1];
  assign mag    = neg_in ? (~value_i + 64'd1) : value_i;

  // shift-add-3 adjust on every bcd digit
  always_comb begin
    for (int i = 0; i < itoa_pkg::BcdDigits; i++) begin
      if (work_q[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] >= 4'd5) begin
        bcd_adj[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] =
          work_q[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] + 4'd3;
      end else begin
        bcd_adj[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] =
          work_q[i*itoa_pkg::DigitW +: itoa_pkg::DigitW];
      end
    end
  end

  always_comb begin
    case (mode_q)
      itoa_pkg::ModeBin: begin
        digit    = {3'b0, work_q[0]};
        work_shr = work_q >> 1;
      end
      itoa_pkg::ModeOct: begin
        digit    = {1'b0, work_q[2:0]};
        work_shr = work_q >> 3;
      end
      default: begin
        digit    = work_q[3:0];
        work_shr = work_q >> 4;
      end
    endcase
  end

  assign conv_step = cmd_i.conv & ~status_o.conv_done;

  assign len  = itoa_pkg::CntW'(neg_q) + n_q;
  assign rem  = len - txt_pos_q;
  assign grp_cnt = (rem > itoa_pkg::CntW'(itoa_pkg::GroupWidth)) ?
                   itoa_pkg::SlotW'(itoa_pkg::GroupWidth) : rem[itoa_pkg::SlotW-1:0];

  assign char_pos = txt_pos_q + itoa_pkg::CntW'(slot_q);
  assign sign_pos = neg_q && (char_pos == '0);
  assign issue    = cmd_i.fill && (slot_q < grp_cnt);
  // text order runs from the top stored digit down
  assign rd_idx   = n_q - itoa_pkg::CntW'(1) - char_pos + itoa_pkg::CntW'(neg_q);
  assign ram_re   = issue & ~sign_pos;

  assign ram_we    = cmd_i.dig | cmd_i.pad;
  assign ram_wdata = cmd_i.dig ? digit : '0;

  assign status_o.conv_done = ~dec_q || (conv_cnt_q == itoa_pkg::CntW'(itoa_pkg::ValueW));
  assign status_o.dig_done  = (work_shr == '0) ||
                              (n_q + itoa_pkg::CntW'(1) >= itoa_pkg::CntW'(itoa_pkg::StoreDepth));
  assign status_o.pad_done  = n_q >= itoa_pkg::CntW'(pad_q);
  assign status_o.fill_done = (slot_q == grp_cnt) && ~pend_valid_q;
  assign status_o.last      = rem <= itoa_pkg::CntW'(itoa_pkg::GroupWidth);

  always_comb begin
    n_d          = n_q;
    conv_cnt_d   = conv_cnt_q;
    txt_pos_d    = txt_pos_q;
    slot_d       = slot_q;
    pend_valid_d = issue;
    if (cmd_i.load) begin
      n_d        = '0;
      conv_cnt_d = '0;
    end
    if (conv_step) begin
      conv_cnt_d = conv_cnt_q + itoa_pkg::CntW'(1);
    end
    if (ram_we) begin
      n_d = n_q + itoa_pkg::CntW'(1);
    end
    if (issue) begin
      slot_d = slot_q + itoa_pkg::SlotW'(1);
    end
    if (cmd_i.grp_start) begin
      txt_pos_d = '0;
      slot_d    = '0;
    end
    if (cmd_i.next_grp) begin
      txt_pos_d = txt_pos_q + itoa_pkg::CntW'(grp_cnt);
      slot_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q          <= '0;
      conv_cnt_q   <= '0;
      txt_pos_q    <= '0;
      slot_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      n_q          <= n_d;
      conv_cnt_q   <= conv_cnt_d;
      txt_pos_q    <= txt_pos_d;
      slot_q       <= slot_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= neg_in;
      mode_q  <= mode_i;
      upper_q <= (mode_i == itoa_pkg::ModeHexUp);
      dec_q   <= !(mode_i == itoa_pkg::ModeBin || mode_i == itoa_pkg::ModeOct ||
                   mode_i == itoa_pkg::ModeHexLow || mode_i == itoa_pkg::ModeHexUp);
      pad_q   <= (min_digits_i > itoa_pkg::MinDigW'(itoa_pkg::PadLimit)) ?
                 itoa_pkg::MinDigW'(itoa_pkg::PadLimit) : min_digits_i;
      bin_q   <= mag;
      if (mode_i == itoa_pkg::ModeBin || mode_i == itoa_pkg::ModeOct ||
          mode_i == itoa_pkg::ModeHexLow || mode_i == itoa_pkg::ModeHexUp) begin
        work_q <= itoa_pkg::WorkW'(mag);
      end else begin
        work_q <= '0;
      end
    end else if (conv_step) begin
      work_q <= {bcd_adj[itoa_pkg::WorkW-2:0], bin_q[itoa_pkg::ValueW-1]};
      bin_q  <= bin_q << 1;
    end else if (cmd_i.dig) begin
      work_q <= work_shr;
    end

    if (issue) begin
      pend_slot_q <= slot_q[itoa_pkg::IdxW-1:0];
      pend_sign_q <= sign_pos;
    end

    if (cmd_i.grp_start || cmd_i.next_grp) begin
      for (int j = 0; j < itoa_pkg::CharFields; j++) begin
        chars_q[j] <= '0;
      end
    end else if (pend_valid_q) begin
      chars_q[pend_slot_q] <= pend_sign_q ? itoa_pkg::CharMinus :
                              itoa_pkg::digit_to_ascii(ram_rdata, upper_q);
    end
  end

  itoa_ram #(
    .WIDTH (itoa_pkg::DigitW),
    .DEPTH (itoa_pkg::StoreDepth)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (n_q[itoa_pkg::AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx[itoa_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign char_first_o  = chars_q[0];
  assign char_second_o = chars_q[1];
  assign char_third_o  = chars_q[2];
  assign char_fourth_o = chars_q[3];
  assign char_count_o  = itoa_pkg::CountW'(grp_cnt);
  assign is_last_o     = status_o.last;

endmodule

`default_nettype wire

@@ rtl/core/itoa_ctrl.sv @@
// ---------------------------------------------------------------------------
// itoa_ctrl
// sequencer: load, convert, collect digits, pad, fill and hand out groups
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output itoa_pkg::cmd_t         cmd_o,
  input  wire itoa_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StDig,
    StPad,
    StFill,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_done) begin
          state_d = StDig;
        end
      end
      StDig: begin
        cmd_o.dig = 1'b1;
        if (status_i.dig_done) begin
          state_d = StPad;
        end
      end
      StPad: begin
        if (status_i.pad_done) begin
          cmd_o.grp_start = 1'b1;
          state_d         = StFill;
        end else begin
          cmd_o.pad = 1'b1;
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_done) begin
          out_valid_d = 1'b1;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          cmd_o.next_grp = 1'b1;
          out_valid_d    = 1'b0;
          state_d        = status_i.last ? StIdle : StFill;
        end
      end
      default: begin
        state_d     = StIdle;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
